>>> rtl/miv_pkg.sv
package miv_pkg;

  localparam int COORD_WIDTH_DEF   = 24;
  localparam int LATTICE_WIDTH_DEF = 21;
  localparam int CFG_W             = 63;
  localparam int CFG_ADDR_W        = 2;
  localparam int FRAC_COORD        = 20;
  localparam int SHIFT_OUT         = 14;
  localparam int RES_W             = 32;
  localparam int SQ_W              = 64;
  localparam int N_IMG             = 27;
  localparam int SQRT_STAGES       = 32;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_LAT_A = 2'd0,
    REG_LAT_B = 2'd1,
    REG_LAT_C = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [SQ_W-1:0]         sq;
    logic signed [RES_W-1:0] x;
    logic signed [RES_W-1:0] y;
    logic signed [RES_W-1:0] z;
  } cand_t;

  // strict less-than keeps the earlier image on a tie
  function automatic cand_t pick_min(cand_t a, cand_t b);
    return (b.sq < a.sq) ? b : a;
  endfunction

endpackage

>>> rtl/miv_image_unit.sv
module miv_image_unit #(
  parameter int CW = miv_pkg::COORD_WIDTH_DEF,
  parameter int LW = miv_pkg::LATTICE_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [CW-1:0]     pt [3],
  input  logic signed [CW-1:0]     ctr [3],
  input  logic [miv_pkg::CFG_W-1:0] lat_reg [3],
  output logic                     out_valid,
  output miv_pkg::cand_t           cand [miv_pkg::N_IMG]
);
  import miv_pkg::*;

  localparam int DW = ((CW > FRAC_COORD) ? CW : FRAC_COORD) + 2;
  localparam int PW = DW + LW;
  localparam int SW = PW + 3;
  localparam logic signed [DW-1:0] ONE = DW'(1 << FRAC_COORD);

  logic [5:0]               vld_r;
  logic signed [LW-1:0]     lat [3][3];
  logic signed [DW-1:0]     d_r [3][3];
  logic signed [PW-1:0]     prod_r [3][3][3];
  logic signed [SW-1:0]     s_r [N_IMG][3];
  logic signed [RES_W-1:0]  v_r [N_IMG][3];
  logic signed [RES_W-1:0]  vd_r [N_IMG][3];
  logic [SQ_W-1:0]          sq_r [N_IMG][3];
  cand_t                    cand_r [N_IMG];

  function automatic logic signed [RES_W-1:0] to_q16(logic signed [SW-1:0] s);
    logic signed [SW-1:0] t;
    logic signed [63:0]   w;
    t = s + SW'(1 << (SHIFT_OUT - 1));
    w = 64'(t) >>> SHIFT_OUT;
    if (w > 64'sh0000_0000_7FFF_FFFF) return 32'h7FFF_FFFF;
    if (w < -64'sd2147483648) return 32'h8000_0000;
    return w[RES_W-1:0];
  endfunction

  always_comb begin
    for (int v = 0; v < 3; v++)
      for (int c = 0; c < 3; c++)
        lat[v][c] = lat_reg[v][c*LW +: LW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int ax = 0; ax < 3; ax++)
        for (int o = 0; o < 3; o++)
          d_r[ax][o] <= DW'(pt[ax]) - DW'(ctr[ax])
                        + ((o == 0) ? -ONE : (o == 2) ? ONE : DW'(0));
      for (int ax = 0; ax < 3; ax++)
        for (int o = 0; o < 3; o++)
          for (int c = 0; c < 3; c++)
            prod_r[ax][o][c] <= PW'(d_r[ax][o]) * PW'(lat[ax][c]);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          for (int k = 0; k < 3; k++)
            for (int c = 0; c < 3; c++)
              s_r[i*9+j*3+k][c] <= SW'(prod_r[0][i][c]) + SW'(prod_r[1][j][c])
                                   + SW'(prod_r[2][k][c]);
      for (int n = 0; n < N_IMG; n++)
        for (int c = 0; c < 3; c++) begin
          v_r[n][c]  <= to_q16(s_r[n][c]);
          sq_r[n][c] <= 64'(v_r[n][c]) * 64'(v_r[n][c]);
          vd_r[n][c] <= v_r[n][c];
        end
      for (int n = 0; n < N_IMG; n++) begin
        cand_r[n].sq <= sq_r[n][0] + sq_r[n][1] + sq_r[n][2];
        cand_r[n].x  <= vd_r[n][0];
        cand_r[n].y  <= vd_r[n][1];
        cand_r[n].z  <= vd_r[n][2];
      end
    end
  end

  assign out_valid = vld_r[5];
  assign cand      = cand_r;

endmodule

>>> rtl/miv_min_tree.sv
module miv_min_tree (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  miv_pkg::cand_t cand [miv_pkg::N_IMG],
  output logic           out_valid,
  output miv_pkg::cand_t best
);
  import miv_pkg::*;

  logic [4:0] vld_r;
  cand_t      l1_r [14];
  cand_t      l2_r [7];
  cand_t      l3_r [4];
  cand_t      l4_r [2];
  cand_t      l5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 13; i++) l1_r[i] <= pick_min(cand[2*i], cand[2*i+1]);
      l1_r[13] <= cand[26];
      for (int i = 0; i < 7; i++) l2_r[i] <= pick_min(l1_r[2*i], l1_r[2*i+1]);
      for (int i = 0; i < 3; i++) l3_r[i] <= pick_min(l2_r[2*i], l2_r[2*i+1]);
      l3_r[3] <= l2_r[6];
      for (int i = 0; i < 2; i++) l4_r[i] <= pick_min(l3_r[2*i], l3_r[2*i+1]);
      l5_r <= pick_min(l4_r[0], l4_r[1]);
    end
  end

  assign out_valid = vld_r[4];
  assign best      = l5_r;

endmodule

>>> rtl/miv_sqrt.sv
module miv_sqrt (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  miv_pkg::cand_t                   cand,
  output logic                             out_valid,
  output logic signed [miv_pkg::RES_W-1:0] path_x,
  output logic signed [miv_pkg::RES_W-1:0] path_y,
  output logic signed [miv_pkg::RES_W-1:0] path_z,
  output logic [miv_pkg::RES_W-1:0]        distance
);
  import miv_pkg::*;

  logic [SQRT_STAGES-1:0] vld_r;
  logic [SQ_W-1:0]        n_r   [SQRT_STAGES];
  logic [SQ_W-1:0]        res_r [SQRT_STAGES];
  cand_t                  c_r   [SQRT_STAGES];
  logic [SQ_W-1:0]        n_nxt   [SQRT_STAGES];
  logic [SQ_W-1:0]        res_nxt [SQRT_STAGES];
  cand_t                  c_nxt   [SQRT_STAGES];

  always_comb begin
    logic [SQ_W-1:0] n_in;
    logic [SQ_W-1:0] r_in;
    logic [SQ_W-1:0] bitv;
    logic [SQ_W-1:0] t;
    for (int s = 0; s < SQRT_STAGES; s++) begin
      n_in     = (s == 0) ? cand.sq : n_r[s-1];
      r_in     = (s == 0) ? '0 : res_r[s-1];
      c_nxt[s] = (s == 0) ? cand : c_r[s-1];
      bitv     = SQ_W'(1) << (SQ_W - 2 - 2*s);
      t        = r_in + bitv;
      if (n_in >= t) begin
        n_nxt[s]   = n_in - t;
        res_nxt[s] = (r_in >> 1) + bitv;
      end else begin
        n_nxt[s]   = n_in;
        res_nxt[s] = r_in >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SQRT_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r   <= n_nxt;
      res_r <= res_nxt;
      c_r   <= c_nxt;
    end
  end

  assign out_valid = vld_r[SQRT_STAGES-1];
  assign path_x    = c_r[SQRT_STAGES-1].x;
  assign path_y    = c_r[SQRT_STAGES-1].y;
  assign path_z    = c_r[SQRT_STAGES-1].z;
  assign distance  = res_r[SQRT_STAGES-1][RES_W-1:0];

endmodule

>>> rtl/minimum_image_vector_unit.sv
// Minimum-image search over the 27 periodic images of a point around a center.
// Input stream (in_*): one transaction carries point and center in fractional
// cell coordinates. Output stream (out_*): one transaction per input with the
// shortest Cartesian image vector (Q16.16) and its floor-root length.
// Lattice vectors are written on the cfg_* port (index 0..2 = a, b, c); other
// indexes are dropped. The user must write them only while the block is idle;
// the block itself does not enforce this. Pipeline from input acceptance to
// out_tvalid: 6 image stages, 5 minimum-tree levels, 32 square-root stages,
// each a register slice. Throughput: one transaction per cycle unless stalled.
// Stall: when out_tvalid is held without out_tready, the whole pipeline
// freezes and in_tready drops in the same cycle; nothing is lost or repeated.
// Reset (rst_n low, synchronous): pipeline valids and lattice registers clear.
module minimum_image_vector_unit #(
  parameter int COORD_WIDTH   = miv_pkg::COORD_WIDTH_DEF,
  parameter int LATTICE_WIDTH = miv_pkg::LATTICE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // point_fx, point_fy, point_fz, center_fx, center_fy, center_fz, zero pad
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // path_x, path_y, path_z, distance
  output logic [4*miv_pkg::RES_W-1:0]      out_tdata,
  input  logic                             cfg_we,
  input  logic [miv_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [miv_pkg::CFG_W-1:0]        cfg_wdata
);
  import miv_pkg::*;

  localparam int CW = COORD_WIDTH;

  logic                    en;
  logic [CFG_W-1:0]        lat_r [3];
  logic signed [CW-1:0]    pt [3];
  logic signed [CW-1:0]    ctr [3];
  logic                    img_valid;
  cand_t                   img_cand [N_IMG];
  logic                    tree_valid;
  cand_t                   best;
  logic signed [RES_W-1:0] path_x;
  logic signed [RES_W-1:0] path_y;
  logic signed [RES_W-1:0] path_z;
  logic [RES_W-1:0]        distance;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      pt[ax]  = in_tdata[ax*CW +: CW];
      ctr[ax] = in_tdata[(ax+3)*CW +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r <= '{default: '0};
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_LAT_A: lat_r[0] <= cfg_wdata;
        REG_LAT_B: lat_r[1] <= cfg_wdata;
        REG_LAT_C: lat_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  miv_image_unit #(.CW(CW), .LW(LATTICE_WIDTH)) u_image (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_tvalid),
    .pt(pt), .ctr(ctr), .lat_reg(lat_r),
    .out_valid(img_valid), .cand(img_cand)
  );

  miv_min_tree u_tree (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(img_valid),
    .cand(img_cand), .out_valid(tree_valid), .best(best)
  );

  miv_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(tree_valid), .cand(best),
    .out_valid(out_tvalid), .path_x(path_x), .path_y(path_y), .path_z(path_z),
    .distance(distance)
  );

  assign out_tdata = {distance, path_z, path_y, path_x};

  a_stall_only_from_sink: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output backpressure");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_zero_path_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && path_x == '0 && path_y == '0 && path_z == '0) |-> distance == '0)
    else $error("nonzero length for zero vector");

endmodule
